// ===== hdl/htd_pkg.sv =====
`timescale 1ns / 1ps

package htd_pkg;

	localparam int OP_W       = 2;
	localparam int ST_W       = 3;
	localparam int SYM_PORT_W = 8;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_BIT     = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_SYMBOL    = 3'd0;
	localparam logic [ST_W-1:0] ST_READY     = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_READY = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_NODE  = 3'd4;

endpackage

// ===== hdl/htd_node_mem.sv =====
`timescale 1ns / 1ps

// node table: leaf flag and symbol in one array, one-child link in another
module htd_node_mem #(
	parameter int DEPTH = 511,
	parameter int IDX_W = 9,
	parameter int SYM_W = 8
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic             rd_leaf,
	output logic [SYM_W-1:0] rd_sym,
	output logic [IDX_W-1:0] rd_one,
	input  logic             nd_we,
	input  logic [IDX_W-1:0] nd_addr,
	input  logic             nd_leaf,
	input  logic [SYM_W-1:0] nd_sym,
	input  logic             ch_we,
	input  logic [IDX_W-1:0] ch_addr,
	input  logic [IDX_W-1:0] ch_data
);

	logic [SYM_W:0]   node_mem  [DEPTH];
	logic [IDX_W-1:0] child_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (nd_we) begin
			node_mem[nd_addr] <= {nd_leaf, nd_sym};
		end
		if (rd_en) begin
			{rd_leaf, rd_sym} <= node_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ch_we) begin
			child_mem[ch_addr] <= ch_data;
		end
		if (rd_en) begin
			rd_one <= child_mem[rd_addr];
		end
	end

endmodule

// ===== hdl/htd_stack_mem.sv =====
`timescale 1ns / 1ps

// stack of interior nodes still waiting for their one child
module htd_stack_mem #(
	parameter int DEPTH = 32,
	parameter int SP_W  = 5,
	parameter int IDX_W = 9
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [SP_W-1:0]  rd_addr,
	output logic [IDX_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [SP_W-1:0]  wr_addr,
	input  logic [IDX_W-1:0] wr_data
);

	logic [IDX_W-1:0] stack_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= stack_mem[rd_addr];
		end
	end

endmodule

// ===== hdl/huffman_tree_decoder.sv =====
`timescale 1ns / 1ps

// channel  signals                                            direction
// in       in_valid in_ready opcode is_interior leaf_symbol   into block
//          message_bit
// out      out_valid out_ready status symbol                  out of block
//
// each item is accepted in S_IDLE, where the accept cycle reads the node table (for a bit)
// or the top of the pending stack (for a node); S_EXEC then writes back and
// forms the result from the registered memory read; in_ready is low in S_EXEC.
// a result waits in the output register; the block stays in S_EXEC
// only while a new result has to replace one not yet taken.
// reset clears the control state; the memories hold no reset value.
module huffman_tree_decoder #(
	parameter int MAX_SYMBOLS = 256,
	parameter int SYMBOL_BITS = 8,
	parameter int STACK_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [htd_pkg::OP_W-1:0]       opcode,
	input  logic                           is_interior,
	input  logic [htd_pkg::SYM_PORT_W-1:0] leaf_symbol,
	input  logic                           message_bit,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [htd_pkg::ST_W-1:0]       status,
	output logic [htd_pkg::SYM_PORT_W-1:0] symbol
);

	localparam int TABLE_SIZE = 2 * MAX_SYMBOLS - 1;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
	localparam int DEP_W      = $clog2(STACK_DEPTH + 1);
	localparam int SP_W       = $clog2(STACK_DEPTH);
	localparam int SYM_PORT_W = htd_pkg::SYM_PORT_W;
	localparam int SYM_W      = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                  state_q;
	logic [htd_pkg::OP_W-1:0] op_q;
	logic                    int_q;
	logic [SYM_W-1:0]        sym_q;
	logic [IDX_W-1:0]        next_q;
	logic [IDX_W-1:0]        cursor_q;
	logic [IDX_W-1:0]        cur_one_q;
	logic [IDX_W-1:0]        root_one_q;
	logic [CNT_W-1:0]        count_q;
	logic [DEP_W-1:0]        depth_q;
	logic                    prev_int_q;
	logic                    ready_q;
	logic                    out_valid_q;
	logic [htd_pkg::ST_W-1:0] status_q;
	logic [SYM_PORT_W-1:0]   symbol_q;

	logic                    accept;
	logic [IDX_W:0]          next_wide;
	logic [IDX_W-1:0]        next_c;

	logic                    n_leaf;
	logic [SYM_W-1:0]        n_sym;
	logic [IDX_W-1:0]        n_one;
	logic [IDX_W-1:0]        parent;

	logic                    pop;
	logic [DEP_W-1:0]        d1;
	logic [DEP_W-1:0]        d2;
	logic                    ld_ok;
	logic                    has_res;
	logic [htd_pkg::ST_W-1:0] res_status;
	logic [SYM_PORT_W-1:0]   res_sym;
	logic                    go;
	logic                    nd_we;
	logic                    ch_we;
	logic                    st_we;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign symbol    = symbol_q;

	// branch target for the incoming bit, known before the table read
	assign next_wide = message_bit ? {1'b0, cur_one_q} : ({1'b0, cursor_q} + (IDX_W + 1)'(1));
	assign next_c    = (next_wide >= (IDX_W + 1)'(TABLE_SIZE)) ? '0 : next_wide[IDX_W-1:0];

	htd_node_mem #(
		.DEPTH (TABLE_SIZE),
		.IDX_W (IDX_W),
		.SYM_W (SYM_W)
	) u_node_mem (
		.clk     (clk),
		.rd_en   (accept && (opcode == htd_pkg::OP_BIT)),
		.rd_addr (next_c),
		.rd_leaf (n_leaf),
		.rd_sym  (n_sym),
		.rd_one  (n_one),
		.nd_we   (nd_we),
		.nd_addr (count_q[IDX_W-1:0]),
		.nd_leaf (!int_q),
		.nd_sym  (int_q ? '0 : sym_q),
		.ch_we   (ch_we),
		.ch_addr (parent),
		.ch_data (count_q[IDX_W-1:0])
	);

	htd_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.SP_W  (SP_W),
		.IDX_W (IDX_W)
	) u_stack_mem (
		.clk     (clk),
		.rd_en   (accept && (opcode == htd_pkg::OP_LOAD)),
		.rd_addr (SP_W'(depth_q - DEP_W'(1))),
		.rd_data (parent),
		.wr_en   (st_we),
		.wr_addr (d1[SP_W-1:0]),
		.wr_data (count_q[IDX_W-1:0])
	);

	// node load checks and bit results, on the state as it stood at accept
	always_comb begin
		pop   = (count_q != '0) && !prev_int_q;
		d1    = pop ? (depth_q - DEP_W'(1)) : depth_q;
		d2    = int_q ? (d1 + DEP_W'(1)) : d1;
		ld_ok = 1'b0;
		has_res    = 1'b0;
		res_status = htd_pkg::ST_SYMBOL;
		res_sym    = '0;
		unique case (op_q)
			htd_pkg::OP_LOAD: begin
				has_res = 1'b1;
				if (ready_q) begin
					res_status = htd_pkg::ST_BAD_NODE;
				end else if ((count_q == '0) && !int_q) begin
					res_status = htd_pkg::ST_BAD_NODE;
				end else if (count_q >= CNT_W'(TABLE_SIZE)) begin
					res_status = htd_pkg::ST_OVERFLOW;
				end else if (pop && (depth_q == '0)) begin
					res_status = htd_pkg::ST_BAD_NODE;
				end else if (int_q && (d1 >= DEP_W'(STACK_DEPTH))) begin
					res_status = htd_pkg::ST_OVERFLOW;
				end else begin
					ld_ok      = 1'b1;
					// last leaf closes the tree
					has_res    = !int_q && (d1 == '0);
					res_status = htd_pkg::ST_READY;
				end
			end
			htd_pkg::OP_BIT: begin
				if (!ready_q) begin
					has_res    = 1'b1;
					res_status = htd_pkg::ST_NOT_READY;
				end else if (n_leaf) begin
					has_res    = 1'b1;
					res_status = htd_pkg::ST_SYMBOL;
					res_sym    = SYM_PORT_W'(n_sym);
				end
			end
			default: begin
			end
		endcase
	end

	assign go    = (state_q == S_EXEC) && !(has_res && out_valid_q && !out_ready);
	assign nd_we = go && ld_ok;
	assign ch_we = go && ld_ok && pop && (parent < IDX_W'(TABLE_SIZE));
	assign st_we = go && ld_ok && int_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			int_q  <= is_interior;
			sym_q  <= leaf_symbol[SYM_W-1:0];
			next_q <= next_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			cur_one_q   <= '0;
			root_one_q  <= '0;
			count_q     <= '0;
			depth_q     <= '0;
			prev_int_q  <= 1'b0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= htd_pkg::ST_SYMBOL;
			symbol_q    <= '0;
		end else begin
			if (go && has_res) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status;
				symbol_q    <= res_sym;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= S_IDLE;
						case (op_q)
							htd_pkg::OP_LOAD: begin
								if (ld_ok) begin
									depth_q    <= d2;
									count_q    <= count_q + CNT_W'(1);
									prev_int_q <= int_q;
									if (pop && (parent == '0)) begin
										root_one_q <= count_q[IDX_W-1:0];
									end
									if (!int_q && (d1 == '0)) begin
										ready_q   <= 1'b1;
										cursor_q  <= '0;
										// the root's one child can be linked by this very leaf
										cur_one_q <= (pop && (parent == '0)) ?
											count_q[IDX_W-1:0] : root_one_q;
									end
								end
							end
							htd_pkg::OP_BIT: begin
								if (ready_q) begin
									if (n_leaf) begin
										cursor_q  <= '0;
										cur_one_q <= root_one_q;
									end else begin
										cursor_q  <= next_q;
										cur_one_q <= n_one;
									end
								end
							end
							htd_pkg::OP_RESTART: begin
								count_q    <= '0;
								depth_q    <= '0;
								prev_int_q <= 1'b0;
								ready_q    <= 1'b0;
								cursor_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_empty_stack: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (depth_q == '0))
		else $error("tree complete with pending interior nodes");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_SIZE))
		else $error("node count beyond table size");

	a_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while previous one in progress");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < IDX_W'(TABLE_SIZE))
		else $error("cursor outside node table");
`endif

endmodule

// ===== bench/tb_huffman_tree_decoder.sv =====
`timescale 1ns / 1ps

module tb_huffman_tree_decoder;

	localparam int OP_W = htd_pkg::OP_W;
	localparam int ST_W = htd_pkg::ST_W;
	localparam int SYM_PORT_W = htd_pkg::SYM_PORT_W;
	localparam int TABLE_SIZE = 2 * 256 - 1;
	localparam int STACK_LIMIT = 32;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]       status;
		logic [SYM_PORT_W-1:0] symbol;
	} result_t;

	class decode_scoreboard;
		bit       leaf_flag[TABLE_SIZE];
		bit [7:0] node_sym[TABLE_SIZE];
		int       one_child[TABLE_SIZE];
		int       pending_parent[STACK_LIMIT];
		int       stack_depth;
		int       node_count;
		bit       prev_interior;
		bit       tree_ready;
		int       cursor;
		int       mismatches;
		result_t  due_results[$];

		function new();
			stack_depth = 0;
			node_count = 0;
			prev_interior = 0;
			tree_ready = 0;
			cursor = 0;
			mismatches = 0;
		endfunction

		function void add_result(logic [ST_W-1:0] st, logic [SYM_PORT_W-1:0] sy);
			due_results.push_back('{status: st, symbol: sy});
		endfunction

		// advance the decoder state by one accepted input item
		function void note_item(logic [OP_W-1:0] op, logic interior,
				logic [SYM_PORT_W-1:0] sym, logic mbit);
			int idx;
			int depth;
			bit pop;
			int nxt;
			idx = node_count;
			depth = stack_depth;
			pop = 0;
			case (op)
			htd_pkg::OP_LOAD: begin
				if (tree_ready)
					add_result(htd_pkg::ST_BAD_NODE, 8'd0);
				else if (idx == 0 && !interior)
					add_result(htd_pkg::ST_BAD_NODE, 8'd0);
				else if (idx >= TABLE_SIZE)
					add_result(htd_pkg::ST_OVERFLOW, 8'd0);
				else if (idx != 0 && !prev_interior && depth == 0)
					add_result(htd_pkg::ST_BAD_NODE, 8'd0);
				else begin
					// a node after a leaf is the one child of the newest pending parent
					if (idx != 0 && !prev_interior) begin
						pop = 1;
						depth--;
					end
					if (interior && depth >= STACK_LIMIT) begin
						add_result(htd_pkg::ST_OVERFLOW, 8'd0);
					end else begin
						if (pop)
							one_child[pending_parent[depth]] = idx;
						leaf_flag[idx] = !interior;
						node_sym[idx] = interior ? 8'd0 : sym;
						one_child[idx] = 0;
						if (interior) begin
							pending_parent[depth] = idx;
							depth++;
						end
						stack_depth = depth;
						node_count = idx + 1;
						prev_interior = interior;
						if (!interior && depth == 0) begin
							tree_ready = 1;
							cursor = 0;
							add_result(htd_pkg::ST_READY, 8'd0);
						end
					end
				end
			end
			htd_pkg::OP_BIT: begin
				if (!tree_ready) begin
					add_result(htd_pkg::ST_NOT_READY, 8'd0);
				end else begin
					if (cursor >= TABLE_SIZE)
						cursor = 0;
					nxt = mbit ? one_child[cursor] : cursor + 1;
					if (nxt >= TABLE_SIZE)
						nxt = 0;
					if (leaf_flag[nxt]) begin
						cursor = 0;
						add_result(htd_pkg::ST_SYMBOL, node_sym[nxt]);
					end else begin
						cursor = nxt;
					end
				end
			end
			htd_pkg::OP_RESTART: begin
				stack_depth = 0;
				node_count = 0;
				prev_interior = 0;
				tree_ready = 0;
				cursor = 0;
			end
			default: ;
			endcase
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [SYM_PORT_W-1:0] sy);
			result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected item: status %0d symbol %0d", st, sy);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (st !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, st);
					mismatches++;
				end
				if (sy !== want.symbol) begin
					$error("symbol: expected %0d, got %0d", want.symbol, sy);
					mismatches++;
				end
			end
		endfunction

		function int waiting();
			return due_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [OP_W-1:0]       opcode;
	logic                  is_interior;
	logic [SYM_PORT_W-1:0] leaf_symbol;
	logic                  message_bit;
	logic                  out_valid;
	logic                  out_ready;
	logic [ST_W-1:0]       status;
	logic [SYM_PORT_W-1:0] symbol;

	decode_scoreboard board = new();
	int in_calm = 0;
	int out_calm = 0;
	int items_sent = 0;

	huffman_tree_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.is_interior(is_interior),
		.leaf_symbol(leaf_symbol),
		.message_bit(message_bit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.symbol(symbol)
	);

	always #5 clk = ~clk;

	// wait before an item; now and then a run of items with no wait at all
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [SYM_PORT_W-1:0] any_symbol();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hff;
		return SYM_PORT_W'($urandom_range(0, 255));
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic interior,
			logic [SYM_PORT_W-1:0] sym, logic mbit);
		int gap;
		gap = draw_wait(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		is_interior <= interior;
		leaf_symbol <= sym;
		message_bit <= mbit;
		do @(posedge clk); while (!in_ready);
		board.note_item(op, interior, sym, mbit);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_load(logic interior, logic [SYM_PORT_W-1:0] sym);
		send_item(htd_pkg::OP_LOAD, interior, sym, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_bits(int count, int ones_pct);
		repeat (count)
			send_item(htd_pkg::OP_BIT, 1'($urandom_range(0, 1)),
				SYM_PORT_W'($urandom_range(0, 255)),
				$urandom_range(0, 99) < ones_pct);
	endtask

	task automatic send_restart();
		send_item(htd_pkg::OP_RESTART, 1'($urandom_range(0, 1)),
			SYM_PORT_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// random full binary tree in preorder; stops after node_limit nodes
	task automatic send_tree(int leaves, int max_open, int node_limit);
		int open_slots;
		int int_left;
		int leaf_left;
		int done;
		bit make_leaf;
		open_slots = 1;
		int_left = leaves - 1;
		leaf_left = leaves;
		done = 0;
		while (int_left + leaf_left > 0 && done < node_limit) begin
			if (int_left == 0)
				make_leaf = 1;
			else if (open_slots == 1 && leaf_left > 1)
				make_leaf = 0;
			else if (open_slots >= max_open)
				make_leaf = 1;
			else
				make_leaf = $urandom_range(0, int_left + leaf_left - 1) >= int_left;
			if (make_leaf) begin
				send_load(1'b0, any_symbol());
				open_slots--;
				leaf_left--;
			end else begin
				send_load(1'b1, SYM_PORT_W'($urandom_range(0, 255)));
				open_slots++;
				int_left--;
			end
			done++;
		end
	endtask

	initial begin
		int pick;
		int leaves;
		int k;
		bit did_full;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = htd_pkg::OP_LOAD;
		is_interior = 1'b0;
		leaf_symbol = '0;
		message_bit = 1'b0;
		did_full = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bits with no tree, leaf as root, unused opcode
		send_item(htd_pkg::OP_BIT, 1'b0, 8'h00, 1'b0);
		send_item(htd_pkg::OP_BIT, 1'b1, 8'hff, 1'b1);
		send_item(htd_pkg::OP_LOAD, 1'b0, 8'hff, 1'b0);
		send_item(OP_UNUSED, 1'b1, 8'h5a, 1'b1);
		// small tree with both symbol extremes
		send_item(htd_pkg::OP_LOAD, 1'b1, 8'h00, 1'b0);
		send_item(htd_pkg::OP_LOAD, 1'b0, 8'h00, 1'b1);
		send_item(htd_pkg::OP_LOAD, 1'b1, 8'hff, 1'b1);
		send_item(htd_pkg::OP_LOAD, 1'b0, 8'hff, 1'b0);
		send_item(htd_pkg::OP_LOAD, 1'b0, 8'ha5, 1'b0);
		send_item(htd_pkg::OP_BIT, 1'b0, 8'h00, 1'b0);
		send_item(htd_pkg::OP_BIT, 1'b0, 8'h00, 1'b1);
		send_item(htd_pkg::OP_BIT, 1'b1, 8'hff, 1'b0);
		send_item(htd_pkg::OP_BIT, 1'b0, 8'h00, 1'b1);
		send_item(htd_pkg::OP_BIT, 1'b1, 8'hff, 1'b1);
		// nodes after the tree is complete, then a bit after a restart
		send_item(htd_pkg::OP_LOAD, 1'b0, 8'h11, 1'b0);
		send_item(htd_pkg::OP_LOAD, 1'b1, 8'h22, 1'b1);
		send_item(htd_pkg::OP_RESTART, 1'b0, 8'h00, 1'b0);
		send_item(htd_pkg::OP_BIT, 1'b0, 8'h00, 1'b1);
		// partial tree dropped by a restart
		send_item(htd_pkg::OP_LOAD, 1'b1, 8'h00, 1'b0);
		send_item(htd_pkg::OP_RESTART, 1'b1, 8'hff, 1'b1);

		while (items_sent < 600) begin
			pick = $urandom_range(0, 99);
			if (!did_full && items_sent >= 40) begin
				// fill the node table without closing the tree, then overflow it
				did_full = 1;
				send_restart();
				send_tree(256, 8, TABLE_SIZE - 1);
				send_load(1'b1, SYM_PORT_W'($urandom_range(0, 255)));
				send_load(1'b0, any_symbol());
				send_load(1'b1, any_symbol());
				send_bits(2, 50);
				send_restart();
			end else if (pick < 55) begin
				send_restart();
				if ($urandom_range(0, 5) == 0)
					send_load(1'b0, any_symbol());
				leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 60)
					: $urandom_range(2, 10);
				send_tree(leaves, $urandom_range(2, 33), 2 * leaves - 1);
				send_bits($urandom_range(8, 40), $urandom_range(20, 80));
				if ($urandom_range(0, 4) == 0)
					send_load(1'($urandom_range(0, 1)), any_symbol());
				if ($urandom_range(0, 4) == 0)
					send_item(OP_UNUSED, 1'($urandom_range(0, 1)),
						SYM_PORT_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 65) begin
				// long zero-branch chain; past the stack limit the interiors overflow
				send_restart();
				k = $urandom_range(30, 35);
				repeat (k)
					send_load(1'b1, SYM_PORT_W'($urandom_range(0, 255)));
				while (!board.tree_ready)
					send_load(1'b0, any_symbol());
				send_bits($urandom_range(20, 60), 15);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 8))
					send_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						SYM_PORT_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				send_restart();
				leaves = $urandom_range(3, 10);
				send_tree(leaves, $urandom_range(2, 12), $urandom_range(1, 2 * leaves - 2));
				send_bits($urandom_range(1, 4), 50);
				if ($urandom_range(0, 1) == 0)
					send_restart();
			end
		end
		in_valid <= 1'b0;

		while (board.waiting() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.waiting() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls between items
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(out_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_result(status, symbol);
		end
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/htd_pkg.sv
hdl/htd_node_mem.sv
hdl/htd_stack_mem.sv
hdl/huffman_tree_decoder.sv
bench/tb_huffman_tree_decoder.sv
